// ===== hdl/mep_pkg.sv =====
// Shared types, constants and the color palette for the escape-time pixel block.
`timescale 1ns / 1ps

package mep_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int FX_W       = 32;
   localparam int SAT_W      = 48;
   localparam int MAX_STEPS  = 512;
   localparam int STEP_W     = 10;
   localparam int IDX_W      = 9;
   localparam int PIX_W      = 12;
   localparam int CFG_W      = 13;
   localparam int DIV_W      = PIX_W + FRAC_BITS;
   localparam int DIV_CNT_W  = 6;
   localparam int PROD_W     = 2 * FX_W;
   localparam int NUM_POINTS = 7;

   localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic signed [SAT_W-1:0] FX_MAX = (48'sd1 <<< (FX_W - 1)) - 48'sd1;
   localparam logic signed [SAT_W-1:0] FX_MIN = -(48'sd1 <<< (FX_W - 1));
   localparam logic signed [SAT_W-1:0] OFFSET_RE = 48'sd3 <<< (FRAC_BITS - 1);
   localparam logic signed [SAT_W-1:0] OFFSET_IM = 48'sd1 <<< (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_RE,
      ST_SAVE_RE,
      ST_DIV_IM,
      ST_SAVE_IM,
      ST_MUL,
      ST_ADD,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic load_re;
      logic div_step;
      logic save_re;
      logic save_im;
      logic mul;
      logic add;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
      logic iter_done;
   } dp_status_type;

   function automatic logic signed [FX_W-1:0] fx_sat(input logic signed [SAT_W-1:0] v);
      logic signed [FX_W-1:0] r;
      if (v > FX_MAX) begin
         r = FX_MAX[FX_W-1:0];
      end else if (v < FX_MIN) begin
         r = FX_MIN[FX_W-1:0];
      end else begin
         r = v[FX_W-1:0];
      end
      return r;
   endfunction

   // {red, green, blue} of each anchor color
   function automatic logic [23:0] point_rgb(input logic [2:0] p);
      logic [23:0] c;
      case (p)
         3'd1:    c = 24'h0000FF;
         3'd2:    c = 24'h00FFFF;
         3'd3:    c = 24'h00FF00;
         3'd4:    c = 24'hFFFF00;
         3'd5:    c = 24'hFF0000;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

   // Blend linearly between anchors, truncating.
   function automatic logic [23:0] palette_rgb(input logic [IDX_W-1:0] idx);
      logic [11:0] scaled;
      logic [2:0]  base;
      logic [2:0]  nxt;
      logic [8:0]  frac;
      logic [9:0]  wa;
      logic [23:0] a;
      logic [23:0] b;
      logic [18:0] acc;
      logic [23:0] rgb;
      scaled = {3'b000, idx} * 12'(NUM_POINTS);
      base   = scaled[11:9];
      frac   = scaled[8:0];
      nxt    = (base == 3'(NUM_POINTS - 1)) ? base : base + 3'd1;
      a      = point_rgb(base);
      b      = point_rgb(nxt);
      wa     = 10'(MAX_STEPS) - {1'b0, frac};
      rgb    = '0;
      for (int ch = 0; ch < 3; ch++) begin
         acc = 19'(a[ch*8 +: 8]) * 19'(wa) + 19'(b[ch*8 +: 8]) * 19'(frac);
         rgb[ch*8 +: 8] = acc[16:9];
      end
      return rgb;
   endfunction

endpackage

// ===== hdl/mep_ctrl.sv =====
// Sequencer for coordinate division, orbit iteration and result strobe.
`timescale 1ns / 1ps

module mep_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output mep_pkg::dp_cmd_type    cmd,
   input  mep_pkg::dp_status_type status
);
   import mep_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (start) state_in = ST_DIV_RE;
         ST_DIV_RE:  if (status.div_last) state_in = ST_SAVE_RE;
         ST_SAVE_RE: state_in = ST_DIV_IM;
         ST_DIV_IM:  if (status.div_last) state_in = ST_SAVE_IM;
         ST_SAVE_IM: state_in = ST_MUL;
         ST_MUL:     state_in = ST_ADD;
         ST_ADD:     state_in = status.iter_done ? ST_RESP : ST_MUL;
         ST_RESP:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.load_re = start;
         end
         ST_DIV_RE:  cmd.div_step = 1'b1;
         ST_SAVE_RE: cmd.save_re  = 1'b1;
         ST_DIV_IM:  cmd.div_step = 1'b1;
         ST_SAVE_IM: cmd.save_im  = 1'b1;
         ST_MUL:     cmd.mul      = 1'b1;
         ST_ADD:     cmd.add      = 1'b1;
         ST_RESP:    rsp_valid    = 1'b1;
         default:    busy         = 1'b1;
      endcase
   end

endmodule

// ===== hdl/mep_datapath.sv =====
// Shared restoring divider, complex square-add unit and palette lookup.
`timescale 1ns / 1ps

module mep_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  mep_pkg::dp_cmd_type          cmd,
   output mep_pkg::dp_status_type       status,
   input  logic [mep_pkg::PIX_W-1:0]    pixel_x,
   input  logic [mep_pkg::PIX_W-1:0]    pixel_y,
   input  logic [mep_pkg::CFG_W-1:0]    frame_width,
   input  logic [mep_pkg::CFG_W-1:0]    frame_height,
   output logic [7:0]                   red,
   output logic [7:0]                   green,
   output logic [7:0]                   blue,
   output logic [mep_pkg::IDX_W-1:0]    escape_step,
   output logic                         escaped
);
   import mep_pkg::*;

   logic [PIX_W-1:0]             pix_y_ff;
   logic [DIV_W-1:0]             num_ff, num_in;
   logic [CFG_W-1:0]             rem_ff, rem_in;
   logic [CFG_W-1:0]             dvs_ff;
   logic [DIV_CNT_W-1:0]         cnt_ff;
   logic [CFG_W:0]               trial;
   logic                         ge;
   logic signed [FX_W-1:0]       c_re_ff, c_im_ff, re_ff, im_ff;
   logic signed [PROD_W-1:0]     rr_ff, ii_ff, ri_ff;
   logic signed [PROD_W-1:0]     rr_in, ii_in, ri_in;
   logic [PROD_W-1:0]            mag_sum;
   logic                         esc;
   logic [STEP_W-1:0]            step_ff, step_m1;
   logic signed [SAT_W-1:0]      re_sum, im_sum;
   logic [23:0]                  rgb;

   assign trial  = {rem_ff, num_ff[DIV_W-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign rem_in = ge ? CFG_W'(trial - {1'b0, dvs_ff}) : trial[CFG_W-1:0];
   assign num_in = {num_ff[DIV_W-2:0], ge};

   assign rr_in = re_ff * re_ff;
   assign ii_in = im_ff * im_ff;
   assign ri_in = re_ff * im_ff;

   // Both squares are non-negative; |z|^2 >= 4 when bits at 2F+2 and up are set.
   assign mag_sum = rr_ff + ii_ff;
   assign esc     = mag_sum[PROD_W-1:2*FRAC_BITS+2] != '0;

   assign re_sum = SAT_W'(signed'(rr_ff[PROD_W-1:FRAC_BITS]))
                 - SAT_W'(signed'(ii_ff[PROD_W-1:FRAC_BITS])) + SAT_W'(c_re_ff);
   assign im_sum = SAT_W'(signed'(ri_ff[PROD_W-1:FRAC_BITS-1])) + SAT_W'(c_im_ff);

   assign step_m1 = step_ff - STEP_W'(1);
   assign rgb     = palette_rgb(step_m1[IDX_W-1:0]);

   assign status.div_last  = cnt_ff == DIV_CNT_W'(DIV_W - 1);
   assign status.iter_done = esc || (step_ff == STEP_W'(MAX_STEPS));

   always_ff @(posedge clock) begin
      if (cmd.load_re) begin
         pix_y_ff <= pixel_y;
         num_ff   <= {pixel_x, FRAC_BITS'(0)};
         dvs_ff   <= (frame_width == '0) ? CFG_W'(1) : frame_width;
         rem_ff   <= '0;
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end else if (cmd.save_re) begin
         c_re_ff <= fx_sat(SAT_W'(num_ff) - OFFSET_RE);
         num_ff  <= {pix_y_ff, FRAC_BITS'(0)};
         dvs_ff  <= (frame_height == '0) ? CFG_W'(1) : frame_height;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.save_im) begin
         c_im_ff <= fx_sat(SAT_W'(num_ff) - OFFSET_IM);
         re_ff   <= '0;
         im_ff   <= '0;
      end
      if (cmd.mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      if (cmd.add && !status.iter_done) begin
         re_ff <= fx_sat(re_sum);
         im_ff <= fx_sat(im_sum);
      end
      if (cmd.add && esc) begin
         red         <= rgb[23:16];
         green       <= rgb[15:8];
         blue        <= rgb[7:0];
         escape_step <= step_m1[IDX_W-1:0];
         escaped     <= 1'b1;
      end else if (cmd.add && status.iter_done) begin
         red         <= '0;
         green       <= '0;
         blue        <= '0;
         escape_step <= '0;
         escaped     <= 1'b0;
      end
   end

   // step_ff counts updates applied to z
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.save_im) begin
         step_ff <= '0;
      end else if (cmd.add && !status.iter_done) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

endmodule

// ===== hdl/mandelbrot_escape_pixel_top.sv =====
// Top level of the escape-time pixel evaluator: registers, sequencer, datapath.
//
//  channel   ports                                  handshake
//  request   req_pixel_x, req_pixel_y               start high while busy low
//  result    rsp_red/green/blue, rsp_escape_step,   rsp_valid high for one cycle
//            rsp_escaped
//  config    csr_index, csr_wdata                   csr_wr_en high, no wait
//
// After the accepting edge, each coordinate division produces one quotient bit
// per cycle on a shared restoring divider, followed by a save state. Each
// orbit step is a multiply stage, then an add/saturate/escape stage. The escape
// test of step n looks at z after n+1 updates, and a result state follows.
// A new request is taken only once the block has returned to idle.
// Reset is synchronous and active high; it clears the sequencer and loads
// frame_width 640 and frame_height 480. The receiver cannot stall: each
// result is shown for exactly one cycle and the block then returns to idle.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [mep_pkg::PIX_W-1:0]  req_pixel_x,
   input  logic [mep_pkg::PIX_W-1:0]  req_pixel_y,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue,
   output logic [mep_pkg::IDX_W-1:0]  rsp_escape_step,
   output logic                       rsp_escaped,
   input  logic                       csr_wr_en,
   input  logic [0:0]                 csr_index,
   input  logic [mep_pkg::CFG_W-1:0]  csr_wdata
);
   import mep_pkg::*;

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   dp_cmd_type       cmd;
   dp_status_type    status;

   // Hold the frame size; write it only while idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(640);
         height_ff <= CFG_W'(480);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   // Sequence division, iteration and the result strobe.
   mep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Divide, iterate z = z*z + c, and look up the palette color.
   mep_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .red          (rsp_red),
      .green        (rsp_green),
      .blue         (rsp_blue),
      .escape_step  (rsp_escape_step),
      .escaped      (rsp_escaped)
   );

   // A result only comes out of a transaction in flight.
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // The strobe lasts exactly one cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // An orbit that never escaped reports black and step zero.
   a_no_escape_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_escaped) |-> (rsp_escape_step == '0 && rsp_red == '0
         && rsp_green == '0 && rsp_blue == '0))
      else $error("non-escaped result not black");

   // An accepted transaction makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the escape-time pixel evaluator with its color palette.
`timescale 1ns / 1ps

module testbench;
   import mep_pkg::*;

   typedef struct {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [IDX_W-1:0] step;
      logic             escaped;
   } pixel_color_type;

   // One row of the directed table; known rows carry a typed-in color.
   typedef struct {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      bit               known;
      pixel_color_type  color;
   } pixel_row_type;

   localparam int  WATCHDOG_LIMIT = 6000;
   localparam int  ITEMS_PER_PHASE = 190;
   localparam int  NUM_PHASES = 5;
   localparam longint FX_LIM = longint'(1) <<< (FX_W - 1);

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [PIX_W-1:0] req_pixel_x = '0;
   logic [PIX_W-1:0] req_pixel_y = '0;
   logic             rsp_valid;
   logic [7:0]       rsp_red;
   logic [7:0]       rsp_green;
   logic [7:0]       rsp_blue;
   logic [IDX_W-1:0] rsp_escape_step;
   logic             rsp_escaped;
   logic             csr_wr_en = 1'b0;
   logic [0:0]       csr_index = REG_FRAME_WIDTH;
   logic [CFG_W-1:0] csr_wdata = '0;

   // Shadow copy of the frame registers as the block holds them.
   logic [CFG_W-1:0] width_reg = 13'd640;
   logic [CFG_W-1:0] height_reg = 13'd480;

   pixel_color_type pending_colors[$];
   int           error_count = 0;
   int           pixels_sent = 0;
   int           colors_seen = 0;
   int           escaped_seen = 0;
   int           idle_cycles = 0;

   always #5 clock = ~clock;

   mandelbrot_escape_pixel_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_escape_step (rsp_escape_step),
      .rsp_escaped     (rsp_escaped),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   function automatic longint clamp_fx(longint v);
      if (v >= FX_LIM) return FX_LIM - 1;
      if (v < -FX_LIM) return -FX_LIM;
      return v;
   endfunction

   // Map a pixel to c, run the orbit, and look up the blended color.
   function automatic pixel_color_type predict_pixel(logic [PIX_W-1:0] px,
                                                     logic [PIX_W-1:0] py);
      pixel_color_type res;
      longint       dw;
      longint       dh;
      longint       c_re;
      longint       c_im;
      longint       re;
      longint       im;
      longint       sq;
      longint       cr;
      logic [64:0]  mag2;
      int           scaled;
      int           base;
      int           nxt;
      int           frac;
      logic [23:0]  anchor [7];
      anchor = '{24'h000000, 24'h0000FF, 24'h00FFFF, 24'h00FF00,
                 24'hFFFF00, 24'hFF0000, 24'h000000};
      res = '{8'd0, 8'd0, 8'd0, '0, 1'b0};
      dw = (width_reg == 0) ? 1 : longint'(width_reg);
      dh = (height_reg == 0) ? 1 : longint'(height_reg);
      c_re = clamp_fx((longint'(px) <<< FRAC_BITS) / dw - (longint'(3) <<< (FRAC_BITS - 1)));
      c_im = clamp_fx((longint'(py) <<< FRAC_BITS) / dh - (longint'(1) <<< (FRAC_BITS - 1)));
      re = 0;
      im = 0;
      for (int i = 0; i < MAX_STEPS; i++) begin
         // floor each product separately, as the squaring stage does
         sq = ((re * re) >>> FRAC_BITS) - ((im * im) >>> FRAC_BITS);
         cr = (re * im) >>> (FRAC_BITS - 1);
         re = clamp_fx(sq + c_re);
         im = clamp_fx(cr + c_im);
         mag2 = 65'(re * re) + 65'(im * im);
         if (mag2 >= (65'd1 << (2 * FRAC_BITS + 2))) begin
            scaled = i * NUM_POINTS;
            base = scaled / MAX_STEPS;
            frac = scaled % MAX_STEPS;
            if (base > NUM_POINTS - 1) base = NUM_POINTS - 1;
            nxt = (base == NUM_POINTS - 1) ? base : base + 1;
            res.red   = 8'((anchor[base][23:16] * (MAX_STEPS - frac)
                            + anchor[nxt][23:16] * frac) / MAX_STEPS);
            res.green = 8'((anchor[base][15:8] * (MAX_STEPS - frac)
                            + anchor[nxt][15:8] * frac) / MAX_STEPS);
            res.blue  = 8'((anchor[base][7:0] * (MAX_STEPS - frac)
                            + anchor[nxt][7:0] * frac) / MAX_STEPS);
            res.step = IDX_W'(i);
            res.escaped = 1'b1;
            return res;
         end
      end
      return res;
   endfunction

   // Write one frame register while the block is idle; keep the shadow in step.
   task automatic write_frame_reg(logic [0:0] idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
   endtask

   // Hold start until the block takes the transaction, then queue its expected color.
   task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                             bit known, pixel_color_type typed);
      bit taken;
      taken = 1'b0;
      @(negedge clock);
      start <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      pending_colors.push_back(known ? typed : predict_pixel(px, py));
      pixels_sent++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain_colors();
      while (pending_colors.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Compare each result against the oldest expectation.
   always @(posedge clock) begin
      pixel_color_type want;
      if (!reset && rsp_valid) begin
         colors_seen++;
         if (rsp_escaped) escaped_seen++;
         if (pending_colors.size() == 0) begin
            $display("%0t: unexpected result rgb=%h%h%h step=%0d escaped=%0b", $time,
                     rsp_red, rsp_green, rsp_blue, rsp_escape_step, rsp_escaped);
            error_count++;
         end else begin
            want = pending_colors.pop_front();
            if (rsp_red !== want.red) begin
               $display("%0t: red expected %h actual %h", $time, want.red, rsp_red);
               error_count++;
            end
            if (rsp_green !== want.green) begin
               $display("%0t: green expected %h actual %h", $time, want.green, rsp_green);
               error_count++;
            end
            if (rsp_blue !== want.blue) begin
               $display("%0t: blue expected %h actual %h", $time, want.blue, rsp_blue);
               error_count++;
            end
            if (rsp_escape_step !== want.step) begin
               $display("%0t: escape_step expected %0d actual %0d", $time, want.step,
                        rsp_escape_step);
               error_count++;
            end
            if (rsp_escaped !== want.escaped) begin
               $display("%0t: escaped expected %0b actual %0b", $time, want.escaped,
                        rsp_escaped);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any cycle with no accepted transaction on either side counts.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_colors.size());
            $display("mandelbrot_escape_pixel_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      pixel_row_type    rows [$];
      pixel_color_type  black_escape;
      pixel_color_type  black_bound;
      logic [CFG_W-1:0] widths [NUM_PHASES];
      logic [CFG_W-1:0] heights [NUM_PHASES];
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      int               span_x;
      int               span_y;
      int               gap;

      black_escape = '{8'd0, 8'd0, 8'd0, '0, 1'b1};
      black_bound  = '{8'd0, 8'd0, 8'd0, '0, 1'b0};
      // Directed rows under the reset frame size 640 x 480.
      rows = '{
         '{12'd4095, 12'd4095, 1'b1, black_escape},  // far corner: escape at step zero
         '{12'd960,  12'd240,  1'b1, black_bound},   // c = 0 exactly: never escapes
         '{12'd0,    12'd0,    1'b0, black_bound},
         '{12'd4095, 12'd0,    1'b0, black_bound},
         '{12'd0,    12'd4095, 1'b0, black_bound},
         '{12'd480,  12'd240,  1'b0, black_bound},   // c = -0.75, slow boundary orbit
         '{12'd640,  12'd480,  1'b0, black_bound},
         '{12'd700,  12'd300,  1'b0, black_bound},
         '{12'd320,  12'd100,  1'b0, black_bound},
         '{12'd1000, 12'd250,  1'b0, black_bound},
         '{12'd980,  12'd300,  1'b0, black_bound},
         '{12'd2730, 12'd1365, 1'b0, black_bound},
         '{12'd1365, 12'd2730, 1'b0, black_bound}
      };
      // Frame sizes per phase: reset size, smallest, one side zero (twice), all ones.
      widths  = '{13'd640, 13'd1, 13'd0,    13'd4096, 13'd8191};
      heights = '{13'd480, 13'd1, 13'd4096, 13'd0,    13'd8191};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].color);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph != 0) begin
            drain_colors();
            write_frame_reg(REG_FRAME_WIDTH, widths[ph]);
            write_frame_reg(REG_FRAME_HEIGHT, heights[ph]);
         end
         span_x = (width_reg == 0) ? 1 : ((width_reg > 4096) ? 4096 : int'(width_reg));
         span_y = (height_reg == 0) ? 1 : ((height_reg > 4096) ? 4096 : int'(height_reg));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // mostly points inside the frame, where orbits run long
            if ($urandom_range(0, 9) < 6) begin
               px = PIX_W'($urandom_range(0, span_x - 1));
               py = PIX_W'($urandom_range(0, span_y - 1));
            end else begin
               px = PIX_W'($urandom);
               py = PIX_W'($urandom);
            end
            // every fourth stretch of 16 items goes back to back
            gap = ((n % 64) < 16) ? 0 : $urandom_range(0, 3);
            repeat (gap) @(negedge clock);
            send_pixel(px, py, 1'b0, black_bound);
         end
      end

      drain_colors();
      repeat (20) @(posedge clock);
      $display("Evaluated %0d pixels across %0d frame sizes, extremes included;",
               pixels_sent, NUM_PHASES);
      $display("%0d results checked, %0d of them escaped.", colors_seen, escaped_seen);
      if (error_count == 0 && pending_colors.size() == 0) begin
         $display("mandelbrot_escape_pixel_top verification clean");
      end else begin
         $display("mandelbrot_escape_pixel_top verification failed");
      end
      $finish;
   end

endmodule
